// File: design/assert_macros.svh
// Shared assertion helpers for the lane queue server.
// LQRR_ASSERT: clocked property, disabled while reset is high.
// LQRR_NEVER: condition must never hold at a clock edge outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define LQRR_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define LQRR_NEVER(name, clk, rst, cond, msg) \
   `LQRR_ASSERT(name, clk, rst, !(cond), msg)

`endif

// File: design/lqrr_pkg.sv
`timescale 1ns / 1ps

package lqrr_pkg;

   // Configuration register indexes
   localparam logic CSR_LANE_COUNT = 1'b0;
   localparam logic CSR_GREEN_TIME = 1'b1;

   localparam logic [3:0] LANE_COUNT_RESET = 4'd4;
   localparam logic [7:0] GREEN_TIME_RESET = 8'd5;

   // Operation issued to the lane queue controller
   typedef enum logic [1:0] {
      QOP_NONE      = 2'd0,
      QOP_PUSH_TAIL = 2'd1,
      QOP_PUSH_HEAD = 2'd2,
      QOP_POP       = 2'd3
   } queue_op_type;

   // Status of the selected lane
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ARRIVE,
      ST_SERVE_RD,
      ST_SERVE_DATA,
      ST_TOTAL,
      ST_TIMER,
      ST_ROTATE,
      ST_PUBLISH
   } state_type;

endpackage

// File: design/lqrr_ram.sv
`timescale 1ns / 1ps

module lqrr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/lqrr_queue_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Head pointer and fill count per lane, plus the slot address unit.
module lqrr_queue_ctrl #(
   parameter int MAX_LANES   = 8,
   parameter int QUEUE_DEPTH = 16,
   localparam int LANE_W = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1,
   localparam int ADDR_W = (MAX_LANES * QUEUE_DEPTH > 1) ? $clog2(MAX_LANES * QUEUE_DEPTH) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lqrr_pkg::queue_op_type    op,
   input  logic [LANE_W-1:0]         lane,
   output lqrr_pkg::queue_status_type status,
   output logic [ADDR_W-1:0]         slot_addr
);

   localparam int HEAD_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W  = $clog2(2 * QUEUE_DEPTH);

   logic [HEAD_W-1:0] head_ff [MAX_LANES];
   logic [CNT_W-1:0]  cnt_ff  [MAX_LANES];

   logic [HEAD_W-1:0] head_sel;
   logic [CNT_W-1:0]  cnt_sel;
   logic [HEAD_W-1:0] head_dec;
   logic [HEAD_W-1:0] head_inc;
   logic [SUM_W-1:0]  tail_sum;
   logic [HEAD_W-1:0] tail_pos;
   logic [HEAD_W-1:0] pos;
   logic              is_push;

   assign head_sel = head_ff[lane];
   assign cnt_sel  = cnt_ff[lane];

   assign status.full  = (cnt_sel >= CNT_W'(QUEUE_DEPTH));
   assign status.empty = (cnt_sel == '0);

   assign is_push = (op == lqrr_pkg::QOP_PUSH_TAIL) || (op == lqrr_pkg::QOP_PUSH_HEAD);

   // Ring arithmetic: wrap by one compare and subtract
   always_comb begin
      head_dec = (head_sel == '0) ? HEAD_W'(QUEUE_DEPTH - 1) : head_sel - 1'b1;
      head_inc = (head_sel == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : head_sel + 1'b1;
      tail_sum = SUM_W'(head_sel) + SUM_W'(cnt_sel);
      if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
         tail_pos = HEAD_W'(tail_sum - SUM_W'(QUEUE_DEPTH));
      end else begin
         tail_pos = HEAD_W'(tail_sum);
      end
      unique case (op)
         lqrr_pkg::QOP_PUSH_TAIL: pos = tail_pos;
         lqrr_pkg::QOP_PUSH_HEAD: pos = head_dec;
         lqrr_pkg::QOP_POP:       pos = head_sel;
         lqrr_pkg::QOP_NONE:      pos = head_sel;
         default:                 pos = head_sel;
      endcase
      slot_addr = ADDR_W'(ADDR_W'(lane) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(pos));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_LANES; i++) begin
            head_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else begin
         unique case (op)
            lqrr_pkg::QOP_PUSH_TAIL: begin
               if (!status.full) cnt_ff[lane] <= cnt_sel + 1'b1;
            end
            lqrr_pkg::QOP_PUSH_HEAD: begin
               if (!status.full) begin
                  head_ff[lane] <= head_dec;
                  cnt_ff[lane]  <= cnt_sel + 1'b1;
               end
            end
            lqrr_pkg::QOP_POP: begin
               if (!status.empty) begin
                  head_ff[lane] <= head_inc;
                  cnt_ff[lane]  <= cnt_sel - 1'b1;
               end
            end
            lqrr_pkg::QOP_NONE: begin
            end
            default: begin
            end
         endcase
      end
   end

   `LQRR_ASSERT(a_push_not_full, clock, reset, is_push |-> !status.full, "push to a full lane")
   `LQRR_ASSERT(a_pop_not_empty, clock, reset, (op == lqrr_pkg::QOP_POP) |-> !status.empty, "pop from an empty lane")
   `LQRR_ASSERT(a_push_counts, clock, reset, is_push |=> (cnt_ff[$past(lane)] == CNT_W'($past(cnt_sel) + 1'b1)), "push did not advance fill count")

endmodule

// File: design/lane_queue_round_robin_server_unit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Lane queue round-robin server. Each request beat is one time tick carrying
// per-lane arrival and priority bits; each tick returns exactly one response
// beat. A small sequencer walks the lanes in use one per cycle, pushing
// arrivals into a shared slot RAM (priority arrivals at the queue head,
// others at the tail, full lanes flagged in drop_mask), then pops one vehicle
// from the green lane, reports its id and wait, updates the saturating
// totals, advances the phase timer and, on expiry, rotates green with an
// iterative compare-and-subtract. A tick walks the lanes in use (lane_count
// clamped to 1..MAX_LANES), then serves, totals, times and publishes into
// the response register; rotation steps are added when green moves, and the
// publish step holds while the previous response is still stalled. The
// single RAM write port serialises the arrival walk. req_stall is high while
// a tick is in progress; a new tick is taken while a finished response still
// waits in the output register. Write configuration only while idle; a write
// in mid-tick is not guarded. The slot RAM is not cleared after reset: only
// written slots are ever read.
module lane_queue_round_robin_server_unit #(
   parameter int MAX_LANES   = 8,
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_arrive_mask,
   input  logic [7:0]  req_priority_mask,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_served_valid,
   output logic [2:0]  rsp_served_lane,
   output logic [15:0] rsp_served_id,
   output logic [15:0] rsp_served_wait,
   output logic [7:0]  rsp_drop_mask,
   output logic [31:0] rsp_total_arrived,
   output logic [31:0] rsp_total_passed,
   output logic [47:0] rsp_total_wait,
   // configuration
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   localparam int LANE_W = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
   localparam int N_W    = $clog2(MAX_LANES + 1);
   localparam int DEPTH  = MAX_LANES * QUEUE_DEPTH;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DATA_W = ID_BITS + 16;

   // Configuration registers
   logic [3:0] lane_count_ff;
   logic [7:0] green_time_ff;

   // Sequencer and tick state
   lqrr_pkg::state_type state_ff, state_in;
   logic [LANE_W-1:0]  lane_ff, lane_in;
   logic [N_W-1:0]     n_ff, n_in;
   logic [N_W-1:0]     rot_ff, rot_in;
   logic [7:0]         arrive_ff, arrive_in;
   logic [7:0]         prio_ff, prio_in;
   logic [7:0]         drop_ff, drop_in;
   logic [LANE_W-1:0]  green_ff, green_in;
   logic [LANE_W-1:0]  slane_ff, slane_in;
   logic [7:0]         phase_ff, phase_in;
   logic [ID_BITS-1:0] next_id_ff, next_id_in;
   logic [15:0]        tick_ff, tick_in;
   logic [31:0]        arrived_ff, arrived_in;
   logic [31:0]        passed_ff, passed_in;
   logic [47:0]        wait_tot_ff, wait_tot_in;
   logic               serve_ff, serve_in;
   logic [ID_BITS-1:0] sid_ff, sid_in;
   logic [15:0]        swait_ff, swait_in;

   // Response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_sv_ff, rsp_sv_in;
   logic [2:0]  rsp_lane_ff, rsp_lane_in;
   logic [15:0] rsp_id_ff, rsp_id_in;
   logic [15:0] rsp_wait_ff, rsp_wait_in;
   logic [7:0]  rsp_drop_ff, rsp_drop_in;
   logic [31:0] rsp_arr_ff, rsp_arr_in;
   logic [31:0] rsp_pass_ff, rsp_pass_in;
   logic [47:0] rsp_wtot_ff, rsp_wtot_in;

   // Queue controller and slot RAM
   lqrr_pkg::queue_op_type     q_op;
   logic [LANE_W-1:0]          q_lane;
   lqrr_pkg::queue_status_type q_stat;
   logic [ADDR_W-1:0]          slot_addr;
   logic                       ram_wr_en;
   logic                       ram_rd_en;
   logic [DATA_W-1:0]          ram_rd_data;

   logic        req_accept;
   logic [3:0]  lane4;
   logic        arr_bit;
   logic [7:0]  phase_next;
   logic [48:0] wait_sum;

   lqrr_queue_ctrl #(
      .MAX_LANES   (MAX_LANES),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue_ctrl (
      .clock     (clock),
      .reset     (reset),
      .op        (q_op),
      .lane      (q_lane),
      .status    (q_stat),
      .slot_addr (slot_addr)
   );

   lqrr_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_addr),
      .wr_data ({next_id_ff, tick_ff}),
      .rd_en   (ram_rd_en),
      .rd_addr (slot_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall  = (state_ff != lqrr_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         lane_count_ff <= lqrr_pkg::LANE_COUNT_RESET;
         green_time_ff <= lqrr_pkg::GREEN_TIME_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            lqrr_pkg::CSR_LANE_COUNT: lane_count_ff <= csr_data[3:0];
            lqrr_pkg::CSR_GREEN_TIME: green_time_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign lane4   = 4'(lane_ff);
   assign arr_bit = (lane4 < 4'd8) && arrive_ff[lane4[2:0]];

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in    = state_ff;
      lane_in     = lane_ff;
      n_in        = n_ff;
      rot_in      = rot_ff;
      arrive_in   = arrive_ff;
      prio_in     = prio_ff;
      drop_in     = drop_ff;
      green_in    = green_ff;
      slane_in    = slane_ff;
      phase_in    = phase_ff;
      next_id_in  = next_id_ff;
      tick_in     = tick_ff;
      arrived_in  = arrived_ff;
      passed_in   = passed_ff;
      wait_tot_in = wait_tot_ff;
      serve_in    = serve_ff;
      sid_in      = sid_ff;
      swait_in    = swait_ff;
      q_op        = lqrr_pkg::QOP_NONE;
      q_lane      = lane_ff;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      phase_next  = (phase_ff != 8'hFF) ? phase_ff + 1'b1 : phase_ff;
      wait_sum    = {1'b0, wait_tot_ff} + 49'(swait_ff);

      // Drain the response register when taken; a load below overrides
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_sv_in    = rsp_sv_ff;
      rsp_lane_in  = rsp_lane_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_wait_in  = rsp_wait_ff;
      rsp_drop_in  = rsp_drop_ff;
      rsp_arr_in   = rsp_arr_ff;
      rsp_pass_in  = rsp_pass_ff;
      rsp_wtot_in  = rsp_wtot_ff;

      unique case (state_ff)
         lqrr_pkg::ST_IDLE: begin
            if (req_accept) begin
               arrive_in = req_arrive_mask;
               prio_in   = req_priority_mask;
               drop_in   = '0;
               lane_in   = '0;
               // Clamp the lane count to 1..MAX_LANES
               if (lane_count_ff == '0) begin
                  n_in = N_W'(1);
               end else if ({1'b0, lane_count_ff} > 5'(MAX_LANES)) begin
                  n_in = N_W'(MAX_LANES);
               end else begin
                  n_in = N_W'(lane_count_ff);
               end
               state_in = lqrr_pkg::ST_ARRIVE;
            end
         end
         lqrr_pkg::ST_ARRIVE: begin
            // One lane per cycle: push or drop its arrival
            if (arr_bit) begin
               if (q_stat.full) begin
                  drop_in[lane4[2:0]] = 1'b1;
               end else begin
                  q_op       = prio_ff[lane4[2:0]] ? lqrr_pkg::QOP_PUSH_HEAD
                                                   : lqrr_pkg::QOP_PUSH_TAIL;
                  ram_wr_en  = 1'b1;
                  next_id_in = next_id_ff + 1'b1;
                  if (arrived_ff != '1) arrived_in = arrived_ff + 1'b1;
               end
            end
            if (lane_ff == LANE_W'(n_ff - 1'b1)) begin
               state_in = lqrr_pkg::ST_SERVE_RD;
            end else begin
               lane_in = lane_ff + 1'b1;
            end
         end
         lqrr_pkg::ST_SERVE_RD: begin
            // Read the green lane's head slot and pop it if the lane is not empty
            q_lane   = green_ff;
            slane_in = green_ff;
            serve_in = !q_stat.empty;
            if (!q_stat.empty) begin
               q_op      = lqrr_pkg::QOP_POP;
               ram_rd_en = 1'b1;
            end
            state_in = lqrr_pkg::ST_SERVE_DATA;
         end
         lqrr_pkg::ST_SERVE_DATA: begin
            if (serve_ff) begin
               sid_in   = ram_rd_data[DATA_W-1:16];
               swait_in = tick_ff - ram_rd_data[15:0];
               if (passed_ff != '1) passed_in = passed_ff + 1'b1;
            end else begin
               sid_in   = '0;
               swait_in = '0;
            end
            state_in = lqrr_pkg::ST_TOTAL;
         end
         lqrr_pkg::ST_TOTAL: begin
            if (serve_ff) begin
               wait_tot_in = wait_sum[48] ? '1 : wait_sum[47:0];
            end
            state_in = lqrr_pkg::ST_TIMER;
         end
         lqrr_pkg::ST_TIMER: begin
            if (phase_next >= green_time_ff) begin
               phase_in = '0;
               rot_in   = N_W'(green_ff) + 1'b1;
               state_in = lqrr_pkg::ST_ROTATE;
            end else begin
               phase_in = phase_next;
               state_in = lqrr_pkg::ST_PUBLISH;
            end
         end
         lqrr_pkg::ST_ROTATE: begin
            // Reduce green + 1 modulo the lane count, one subtract per cycle
            if (rot_ff >= n_ff) begin
               rot_in = rot_ff - n_ff;
            end else begin
               green_in = LANE_W'(rot_ff);
               state_in = lqrr_pkg::ST_PUBLISH;
            end
         end
         lqrr_pkg::ST_PUBLISH: begin
            // Hold until the response register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_sv_in    = serve_ff;
               rsp_lane_in  = 3'(slane_ff);
               rsp_id_in    = 16'(sid_ff);
               rsp_wait_in  = swait_ff;
               rsp_drop_in  = drop_ff;
               rsp_arr_in   = arrived_ff;
               rsp_pass_in  = passed_ff;
               rsp_wtot_in  = wait_tot_ff;
               tick_in      = tick_ff + 1'b1;
               state_in     = lqrr_pkg::ST_IDLE;
            end
         end
         default: state_in = lqrr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lqrr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         green_ff     <= '0;
         phase_ff     <= '0;
         next_id_ff   <= ID_BITS'(1);
         tick_ff      <= '0;
         arrived_ff   <= '0;
         passed_ff    <= '0;
         wait_tot_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         lane_ff      <= '0;
         n_ff         <= N_W'(1);
      end else begin
         green_ff     <= green_in;
         phase_ff     <= phase_in;
         next_id_ff   <= next_id_in;
         tick_ff      <= tick_in;
         arrived_ff   <= arrived_in;
         passed_ff    <= passed_in;
         wait_tot_ff  <= wait_tot_in;
         rsp_valid_ff <= rsp_valid_in;
         lane_ff      <= lane_in;
         n_ff         <= n_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rot_ff      <= rot_in;
      arrive_ff   <= arrive_in;
      prio_ff     <= prio_in;
      drop_ff     <= drop_in;
      slane_ff    <= slane_in;
      serve_ff    <= serve_in;
      sid_ff      <= sid_in;
      swait_ff    <= swait_in;
      rsp_sv_ff   <= rsp_sv_in;
      rsp_lane_ff <= rsp_lane_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_wait_ff <= rsp_wait_in;
      rsp_drop_ff <= rsp_drop_in;
      rsp_arr_ff  <= rsp_arr_in;
      rsp_pass_ff <= rsp_pass_in;
      rsp_wtot_ff <= rsp_wtot_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_served_valid  = rsp_sv_ff;
   assign rsp_served_lane   = rsp_lane_ff;
   assign rsp_served_id     = rsp_id_ff;
   assign rsp_served_wait   = rsp_wait_ff;
   assign rsp_drop_mask     = rsp_drop_ff;
   assign rsp_total_arrived = rsp_arr_ff;
   assign rsp_total_passed  = rsp_pass_ff;
   assign rsp_total_wait    = rsp_wtot_ff;

   `LQRR_ASSERT(a_accept_blocks, clock, reset, req_accept |=> req_stall, "tick accepted but block still ready")
   `LQRR_ASSERT(a_lane_in_range, clock, reset, (state_ff == lqrr_pkg::ST_ARRIVE) |-> (lane_ff <= LANE_W'(n_ff - 1'b1)), "arrival walk past last lane")
   `LQRR_ASSERT(a_rsp_from_publish, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == lqrr_pkg::ST_PUBLISH), "response raised outside publish")
   `LQRR_ASSERT(a_served_counted, clock, reset, (rsp_valid_ff && rsp_sv_ff) |-> (rsp_pass_ff != '0), "served vehicle not counted")

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int LANE_LIMIT  = 8;
   localparam int QUEUE_SLOTS = 16;

   // One response beat, field for field as the block drives it.
   typedef struct packed {
      logic        served_valid;
      logic [2:0]  served_lane;
      logic [15:0] served_id;
      logic [15:0] served_wait;
      logic [7:0]  drop_mask;
      logic [31:0] total_arrived;
      logic [31:0] total_passed;
      logic [47:0] total_wait;
   } tick_outcome_type;

   // Mirrors the lane queues tick by tick and holds the outcomes still owed by the block.
   class lane_tick_checker;
      bit [15:0]   slot_id   [LANE_LIMIT][QUEUE_SLOTS];
      bit [15:0]   slot_tick [LANE_LIMIT][QUEUE_SLOTS];
      bit [3:0]    head      [LANE_LIMIT];
      int unsigned waiting   [LANE_LIMIT];
      bit [2:0]    green;
      int unsigned timer;
      bit [15:0]   next_id;
      bit [15:0]   tick;
      bit [31:0]   arrived_sum;
      bit [31:0]   passed_sum;
      bit [47:0]   wait_sum;
      bit [3:0]    lanes_reg;
      bit [7:0]    green_reg;
      tick_outcome_type due_outcomes[$];
      int          errors;
      int          served_count;
      int          drop_count;

      function new();
         foreach (head[i]) begin
            head[i]    = '0;
            waiting[i] = 0;
         end
         green        = '0;
         timer        = 0;
         next_id      = 16'd1;
         tick         = '0;
         arrived_sum  = '0;
         passed_sum   = '0;
         wait_sum     = '0;
         lanes_reg    = lqrr_pkg::LANE_COUNT_RESET;
         green_reg    = lqrr_pkg::GREEN_TIME_RESET;
         errors       = 0;
         served_count = 0;
         drop_count   = 0;
      endfunction

      function void set_register(logic idx, logic [7:0] data);
         if (idx == lqrr_pkg::CSR_LANE_COUNT) begin
            lanes_reg = data[3:0];
         end else begin
            green_reg = data;
         end
      endfunction

      function tick_outcome_type compute_tick_outcome(logic [7:0] arrive, logic [7:0] prio);
         tick_outcome_type r;
         int unsigned   n;
         int unsigned   lane;
         int unsigned   pos;
         int unsigned   g;
         bit [48:0]     sum;
         r = '0;
         n = (lanes_reg == 0) ? 1 : ((lanes_reg > LANE_LIMIT) ? LANE_LIMIT : lanes_reg);
         // arrivals first, lane by lane
         for (lane = 0; lane < n; lane++) begin
            if (!arrive[lane]) continue;
            if (waiting[lane] >= QUEUE_SLOTS) begin
               r.drop_mask[lane] = 1'b1;
               continue;
            end
            if (prio[lane]) begin
               head[lane] = head[lane] - 4'd1;
               pos = 32'(head[lane]);
            end else begin
               pos = (32'(head[lane]) + waiting[lane]) % QUEUE_SLOTS;
            end
            slot_id[lane][pos]   = next_id;
            slot_tick[lane][pos] = tick;
            waiting[lane]++;
            next_id = next_id + 16'd1;
            if (arrived_sum != '1) arrived_sum++;
         end
         // then one departure from the green lane
         g = 32'(green);
         r.served_lane = green;
         if (waiting[g] != 0) begin
            r.served_valid = 1'b1;
            r.served_id    = slot_id[g][head[g]];
            r.served_wait  = tick - slot_tick[g][head[g]];
            head[g]        = head[g] + 4'd1;
            waiting[g]--;
            if (passed_sum != '1) passed_sum++;
            sum = 49'(wait_sum) + 49'(r.served_wait);
            wait_sum = sum[48] ? '1 : sum[47:0];
         end
         r.total_arrived = arrived_sum;
         r.total_passed  = passed_sum;
         r.total_wait    = wait_sum;
         if (timer < 255) timer++;
         if (timer >= green_reg) begin
            green = 3'((g + 1) % n);
            timer = 0;
         end
         tick = tick + 16'd1;
         return r;
      endfunction

      function void note_tick(logic [7:0] arrive, logic [7:0] prio);
         tick_outcome_type r;
         r = compute_tick_outcome(arrive, prio);
         served_count += r.served_valid;
         drop_count   += $countones(r.drop_mask);
         due_outcomes.push_back(r);
      endfunction

      function int pending();
         return due_outcomes.size();
      endfunction

      function void compare_field(string field, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_outcome(tick_outcome_type seen);
         tick_outcome_type want;
         if (due_outcomes.size() == 0) begin
            $error("response beat with no tick outstanding");
            errors++;
            return;
         end
         want = due_outcomes.pop_front();
         compare_field("served_valid", 64'(want.served_valid), 64'(seen.served_valid));
         compare_field("served_lane", 64'(want.served_lane), 64'(seen.served_lane));
         compare_field("served_id", 64'(want.served_id), 64'(seen.served_id));
         compare_field("served_wait", 64'(want.served_wait), 64'(seen.served_wait));
         compare_field("drop_mask", 64'(want.drop_mask), 64'(seen.drop_mask));
         compare_field("total_arrived", 64'(want.total_arrived), 64'(seen.total_arrived));
         compare_field("total_passed", 64'(want.total_passed), 64'(seen.total_passed));
         compare_field("total_wait", 64'(want.total_wait), 64'(seen.total_wait));
      endfunction

      function void check_drained();
         if (due_outcomes.size() != 0) begin
            $error("%0d ticks never answered", due_outcomes.size());
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_arrive_mask;
   logic [7:0]  req_priority_mask;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_served_valid;
   logic [2:0]  rsp_served_lane;
   logic [15:0] rsp_served_id;
   logic [15:0] rsp_served_wait;
   logic [7:0]  rsp_drop_mask;
   logic [31:0] rsp_total_arrived;
   logic [31:0] rsp_total_passed;
   logic [47:0] rsp_total_wait;
   logic        csr_wr_en;
   logic        csr_index;
   logic [7:0]  csr_data;

   lane_tick_checker tracker;

   // Idle controls: quiet turns off all idling for the closing stretch; the calm flags
   // give whole phases without gaps on one side.
   bit quiet       = 1'b0;
   bit source_calm = 1'b0;
   bit sink_calm   = 1'b0;
   int ticks_sent  = 0;
   int settings_used = 0;
   int stall_left  = 0;

   lane_queue_round_robin_server_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_arrive_mask   (req_arrive_mask),
      .req_priority_mask (req_priority_mask),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_served_valid  (rsp_served_valid),
      .rsp_served_lane   (rsp_served_lane),
      .rsp_served_id     (rsp_served_id),
      .rsp_served_wait   (rsp_served_wait),
      .rsp_drop_mask     (rsp_drop_mask),
      .rsp_total_arrived (rsp_total_arrived),
      .rsp_total_passed  (rsp_total_passed),
      .rsp_total_wait    (rsp_total_wait),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #5 clock = ~clock;

   // Response side: stall in randomly started bursts, changed only on the falling edge.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (quiet || sink_calm) begin
            stall_left = 0;
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 99) < 20) stall_left = $urandom_range(1, 6);
         end
      end
   end

   // Check every response beat the moment it is taken.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_outcome('{served_valid:  rsp_served_valid,
                                 served_lane:   rsp_served_lane,
                                 served_id:     rsp_served_id,
                                 served_wait:   rsp_served_wait,
                                 drop_mask:     rsp_drop_mask,
                                 total_arrived: rsp_total_arrived,
                                 total_passed:  rsp_total_passed,
                                 total_wait:    rsp_total_wait});
      end
   end

   function automatic logic [7:0] random_mask(int pct);
      logic [7:0] m;
      for (int b = 0; b < 8; b++) m[b] = ($urandom_range(0, 99) < pct);
      return m;
   endfunction

   // Present one tick as a request beat, hold it until taken, then log it with the tracker.
   // Valid stays high afterwards; the next call either replaces the payload or drops valid.
   task automatic send_tick(input logic [7:0] arrive, input logic [7:0] prio);
      int gap;
      if (!quiet && !source_calm && $urandom_range(0, 99) < 25) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_arrive_mask   <= arrive;
      req_priority_mask <= prio;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_tick(arrive, prio);
      ticks_sent++;
   endtask

   // Drop valid and hold until every tick has been answered, so the block is idle.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [7:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      tracker.set_register(idx, data);
      settings_used++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int         phase;
      int         arrive_pct;
      int         prio_pct;
      int         guard;
      int         pick;
      logic [7:0] lane_val;
      logic [7:0] green_val;

      tracker           = new();
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_arrive_mask   = '0;
      req_priority_mask = '0;
      csr_wr_en         = 1'b0;
      csr_index         = lqrr_pkg::CSR_LANE_COUNT;
      csr_data          = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty tick, all lanes at once, all priority, mixed patterns; unused
      // upper lanes must be ignored under the reset lane count.
      send_tick(8'h00, 8'h00);
      send_tick(8'hFF, 8'h00);
      send_tick(8'hFF, 8'hFF);
      send_tick(8'h55, 8'hAA);
      send_tick(8'hAA, 8'h55);
      settle();

      // All eight lanes, green parked: every lane but the green one fills and then drops.
      write_reg(lqrr_pkg::CSR_LANE_COUNT, 8'd8);
      write_reg(lqrr_pkg::CSR_GREEN_TIME, 8'd255);
      repeat (17) send_tick(8'hFF, random_mask(50));
      settle();

      // Lane count zero acts as one, green time zero rotates every tick, and the green
      // lane now sits beyond the lane count.
      write_reg(lqrr_pkg::CSR_LANE_COUNT, 8'd0);
      write_reg(lqrr_pkg::CSR_GREEN_TIME, 8'd0);
      send_tick(8'hFF, 8'h00);
      send_tick(8'hFF, 8'h01);
      send_tick(8'h01, 8'hFF);

      // Random phases: new lane count and green time each phase, varied traffic load.
      for (phase = 0; phase < 10; phase++) begin
         settle();
         case (phase)
            0:       lane_val = 8'd15;
            1:       lane_val = 8'd1;
            2:       lane_val = 8'd8;
            default: lane_val = 8'($urandom_range(0, 15));
         endcase
         pick = $urandom_range(0, 9);
         if (phase == 0 || pick == 0) green_val = (phase == 0) ? 8'd1 : 8'd0;
         else if (phase == 1 || pick == 1) green_val = 8'd255;
         else green_val = 8'($urandom_range(1, 12));
         write_reg(lqrr_pkg::CSR_LANE_COUNT, lane_val);
         write_reg(lqrr_pkg::CSR_GREEN_TIME, green_val);
         case ($urandom_range(0, 3))
            0:       arrive_pct = 15;
            1:       arrive_pct = 45;
            2:       arrive_pct = 75;
            default: arrive_pct = 100;
         endcase
         prio_pct    = $urandom_range(0, 2) * 35;
         source_calm = ($urandom_range(0, 3) == 0);
         sink_calm   = ($urandom_range(0, 3) == 0);
         repeat (150) begin
            if ($urandom_range(0, 9) == 0) begin
               send_tick(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end else begin
               send_tick(random_mask(arrive_pct), random_mask(prio_pct));
            end
         end
      end

      // Closing stretch, no idling: a run on two lanes under heavy arrivals keeps both
      // queues near full, with drops and long queued waits, up to the drain.
      settle();
      quiet = 1'b1;
      write_reg(lqrr_pkg::CSR_LANE_COUNT, 8'd2);
      write_reg(lqrr_pkg::CSR_GREEN_TIME, 8'd200);
      repeat (275) begin
         send_tick(8'($urandom_range(0, 255)) | 8'h03, 8'($urandom_range(0, 255)));
      end

      // Drain: drop valid, hold for outstanding beats under a limit, then a short tail.
      @(negedge clock);
      req_valid <= 1'b0;
      guard = 0;
      while (tracker.pending() != 0 && guard < 10000) begin
         @(posedge clock);
         guard++;
      end
      repeat (30) @(posedge clock);
      tracker.check_drained();

      $display("Ran %0d ticks across %0d register writes:", ticks_sent, settings_used);
      $display("%0d vehicles served, %0d arrivals dropped",
               tracker.served_count, tracker.drop_count);
      if (tracker.errors == 0) begin
         $display("lane_queue_round_robin_server_unit verification clean");
      end else begin
         $display("lane_queue_round_robin_server_unit verification failed");
      end
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #5_000_000;
      $display("lane_queue_round_robin_server_unit verification failed");
      $finish;
   end

endmodule
